/* sv/fops_pkg.sv */
// ----------------------------------------------------------------------------
// fops_pkg
// Types, codes and the control store of the frequency operating point
// selector.
// ----------------------------------------------------------------------------
`default_nettype none

package fops_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int FREQ_W          = 22;
	localparam int LEN_W           = 5;
	localparam int OUT_IDX_W       = 4;
	localparam int CFG_IDX_W       = 3;

	typedef logic [FREQ_W-1:0]    freq_t;
	typedef logic [LEN_W-1:0]     len_t;
	typedef logic [OUT_IDX_W-1:0] index_t;
	typedef logic [CFG_IDX_W-1:0] cfg_index_t;

	localparam freq_t FREQ_MAX = {FREQ_W{1'b1}};

	localparam cfg_index_t REG_POLICY_MIN   = 3'd0;
	localparam cfg_index_t REG_POLICY_MAX   = 3'd1;
	localparam cfg_index_t REG_QOS_MIN      = 3'd2;
	localparam cfg_index_t REG_QOS_MAX      = 3'd3;
	localparam cfg_index_t REG_TABLE_LENGTH = 3'd4;

	typedef enum logic [1:0] {
		MODE_LOAD    = 2'd0,
		MODE_REQUEST = 2'd1,
		MODE_SUSPEND = 2'd2,
		MODE_RESUME  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_BUSY     = 2'd1,
		STATUS_NO_ENTRY = 2'd2
	} status_t;

	typedef struct packed {
		mode_t  mode;
		index_t entry_index;
		freq_t  freq_khz;
		logic   entry_invalid;
		logic   relation_high;
	} req_item_t;

	typedef struct packed {
		status_t status;
		index_t  chosen_index;
		freq_t   current_khz;
		logic    changed;
	} rsp_item_t;

	typedef struct packed {
		logic  invalid;
		freq_t freq;
	} entry_t;

	// microcode
	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_LOAD,
		OP_CLAMP_LO,
		OP_CLAMP_HI,
		OP_SCAN,
		OP_DECIDE,
		OP_BUSY,
		OP_SAVE,
		OP_PARK,
		OP_RESTORE,
		OP_EMIT
	} uop_t;

	typedef enum logic [1:0] {
		W_NONE,
		W_INPUT,
		W_OUTPUT
	} uwait_t;

	typedef enum logic [2:0] {
		J_NEXT,
		J_GOTO,
		J_MODE,
		J_SUSP,
		J_EMPTY,
		J_MORE
	} ujump_t;

	typedef logic [3:0] upc_t;

	typedef struct packed {
		uop_t   op;
		uwait_t wait_sel;
		ujump_t jump;
		upc_t   target;
	} uword_t;

	localparam upc_t P_WAIT = 4'd0;
	localparam upc_t P_DISP = 4'd1;
	localparam upc_t P_LOAD = 4'd2;
	localparam upc_t P_REQ  = 4'd3;
	localparam upc_t P_CHI  = 4'd4;
	localparam upc_t P_SCAN = 4'd5;
	localparam upc_t P_LAST = 4'd6;
	localparam upc_t P_DEC  = 4'd7;
	localparam upc_t P_BUSY = 4'd8;
	localparam upc_t P_SUSP = 4'd9;
	localparam upc_t P_PARK = 4'd10;
	localparam upc_t P_RES  = 4'd11;
	localparam upc_t P_FIN  = 4'd12;

	function automatic uword_t ucode(input upc_t pc);
		uword_t w;
		w = '{op: OP_NOP, wait_sel: W_NONE, jump: J_GOTO, target: P_WAIT};
		case (pc)
			P_WAIT: w = '{op: OP_ACCEPT,   wait_sel: W_INPUT,  jump: J_NEXT,  target: P_WAIT};
			P_DISP: w = '{op: OP_NOP,      wait_sel: W_NONE,   jump: J_MODE,  target: P_WAIT};
			P_LOAD: w = '{op: OP_LOAD,     wait_sel: W_NONE,   jump: J_GOTO,  target: P_FIN};
			P_REQ:  w = '{op: OP_CLAMP_LO, wait_sel: W_NONE,   jump: J_SUSP,  target: P_BUSY};
			P_CHI:  w = '{op: OP_CLAMP_HI, wait_sel: W_NONE,   jump: J_EMPTY, target: P_DEC};
			P_SCAN: w = '{op: OP_SCAN,     wait_sel: W_NONE,   jump: J_MORE,  target: P_SCAN};
			P_LAST: w = '{op: OP_NOP,      wait_sel: W_NONE,   jump: J_NEXT,  target: P_WAIT};
			P_DEC:  w = '{op: OP_DECIDE,   wait_sel: W_NONE,   jump: J_GOTO,  target: P_FIN};
			P_BUSY: w = '{op: OP_BUSY,     wait_sel: W_NONE,   jump: J_GOTO,  target: P_FIN};
			P_SUSP: w = '{op: OP_SAVE,     wait_sel: W_NONE,   jump: J_NEXT,  target: P_WAIT};
			P_PARK: w = '{op: OP_PARK,     wait_sel: W_NONE,   jump: J_GOTO,  target: P_FIN};
			P_RES:  w = '{op: OP_RESTORE,  wait_sel: W_NONE,   jump: J_GOTO,  target: P_FIN};
			P_FIN:  w = '{op: OP_EMIT,     wait_sel: W_OUTPUT, jump: J_GOTO,  target: P_WAIT};
			default: w = '{op: OP_NOP,     wait_sel: W_NONE,   jump: J_GOTO,  target: P_WAIT};
		endcase
		return w;
	endfunction

	function automatic upc_t mode_target(input mode_t mode);
		upc_t t;
		case (mode)
			MODE_LOAD:    t = P_LOAD;
			MODE_REQUEST: t = P_REQ;
			MODE_SUSPEND: t = P_SUSP;
			MODE_RESUME:  t = P_RES;
			default:      t = P_WAIT;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

/* sv/frequency_operating_point_selector_core.sv */
// ----------------------------------------------------------------------------
// frequency_operating_point_selector_core
// Operating point table with request clamping, table search and
// suspend/resume, run by a small microprogram.
// ----------------------------------------------------------------------------
// One item is taken at a time and answered by exactly one result item. A
// normal request searches the table entries in use (the configured table
// length, capped at the table depth): the search reads one entry per cycle
// through the single read port of the table memory. The next item is
// accepted while the previous result still waits in the output register.
`default_nettype none

module frequency_operating_point_selector_core #(
	parameter int TABLE_DEPTH = fops_pkg::TABLE_DEPTH_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   req_valid,
	output logic                  req_stall,
	input  fops_pkg::req_item_t   req,
	output logic                  rsp_valid,
	input  wire                   rsp_stall,
	output fops_pkg::rsp_item_t   rsp,
	input  wire                   cfg_we,
	input  fops_pkg::cfg_index_t  cfg_index,
	input  fops_pkg::freq_t       cfg_data
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// configuration
	fops_pkg::freq_t policy_min_q, policy_max_q, qos_min_q, qos_max_q;
	fops_pkg::len_t  table_length_q;

	// sequencer
	fops_pkg::upc_t   upc_q, upc_next;
	fops_pkg::uword_t uw;
	logic             req_accept, out_blocked, hold, jump_taken;

	// datapath
	fops_pkg::req_item_t item_q;
	fops_pkg::freq_t     target_q, current_q, saved_q, old_q;
	logic                suspended_q, high_q;
	fops_pkg::status_t   status_q;
	fops_pkg::index_t    chosen_q;
	logic [CNT_W-1:0]    cnt_q, n_used;
	logic [CNT_W:0]      cnt_inc;
	logic                have_best_q, have_alt_q;
	fops_pkg::freq_t     best_f_q, alt_f_q;
	logic [IDX_W-1:0]    best_i_q, alt_i_q;
	fops_pkg::freq_t     lo_a, hi_a;

	// table memory
	fops_pkg::entry_t    mem [TABLE_DEPTH];
	fops_pkg::entry_t    rd_s1;
	logic [IDX_W-1:0]    rd_addr;
	logic                cmp_valid_s1;
	logic [IDX_W-1:0]    cmp_idx_s1;

	logic                rsp_valid_q;
	fops_pkg::rsp_item_t rsp_q;

	assign uw          = fops_pkg::ucode(upc_q);
	assign req_stall   = (uw.op != fops_pkg::OP_ACCEPT);
	assign req_accept  = req_valid && !req_stall;
	assign out_blocked = rsp_valid_q && rsp_stall;
	assign rsp_valid   = rsp_valid_q;
	assign rsp         = rsp_q;

	assign n_used  = (table_length_q > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
	                                                : CNT_W'(table_length_q);
	assign cnt_inc = {1'b0, cnt_q} + 1'b1;

	always_comb begin
		hold = 1'b0;
		case (uw.wait_sel)
			fops_pkg::W_INPUT:  hold = !req_accept;
			fops_pkg::W_OUTPUT: hold = out_blocked;
			default:            hold = 1'b0;
		endcase
		jump_taken = 1'b0;
		case (uw.jump)
			fops_pkg::J_GOTO:  jump_taken = 1'b1;
			fops_pkg::J_SUSP:  jump_taken = suspended_q;
			fops_pkg::J_EMPTY: jump_taken = (n_used == '0);
			fops_pkg::J_MORE:  jump_taken = (cnt_inc < {1'b0, n_used});
			default:           jump_taken = 1'b0;
		endcase
		if (hold) begin
			upc_next = upc_q;
		end else if (uw.jump == fops_pkg::J_MODE) begin
			upc_next = fops_pkg::mode_target(item_q.mode);
		end else if (jump_taken) begin
			upc_next = uw.target;
		end else begin
			upc_next = upc_q + 1'b1;
		end
	end

	// clamp arithmetic
	always_comb begin
		lo_a = (item_q.freq_khz < policy_min_q) ? policy_min_q : item_q.freq_khz;
		if (lo_a < qos_min_q) begin
			lo_a = qos_min_q;
		end
		hi_a = (target_q > policy_max_q) ? policy_max_q : target_q;
		if (hi_a > qos_max_q) begin
			hi_a = qos_max_q;
		end
	end

	assign rd_addr = (uw.op == fops_pkg::OP_SAVE) ? '0 : cnt_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (uw.op == fops_pkg::OP_LOAD && {28'd0, item_q.entry_index} < TABLE_DEPTH) begin
			mem[IDX_W'(item_q.entry_index)] <= '{invalid: item_q.entry_invalid,
			                                    freq: item_q.freq_khz};
		end
		rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_min_q   <= '0;
			policy_max_q   <= fops_pkg::FREQ_MAX;
			qos_min_q      <= '0;
			qos_max_q      <= fops_pkg::FREQ_MAX;
			table_length_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				fops_pkg::REG_POLICY_MIN:   policy_min_q   <= cfg_data;
				fops_pkg::REG_POLICY_MAX:   policy_max_q   <= cfg_data;
				fops_pkg::REG_QOS_MIN:      qos_min_q      <= cfg_data;
				fops_pkg::REG_QOS_MAX:      qos_max_q      <= cfg_data;
				fops_pkg::REG_TABLE_LENGTH: table_length_q <= cfg_data[fops_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q        <= fops_pkg::P_WAIT;
			current_q    <= '0;
			saved_q      <= '0;
			suspended_q  <= 1'b0;
			cmp_valid_s1 <= 1'b0;
			have_best_q  <= 1'b0;
			have_alt_q   <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			upc_q        <= upc_next;
			cmp_valid_s1 <= (uw.op == fops_pkg::OP_SCAN);

			// search compare on the entry read in the previous cycle
			if (cmp_valid_s1 && !rd_s1.invalid) begin
				if (high_q) begin
					if (rd_s1.freq <= target_q) begin
						if (!have_best_q || rd_s1.freq >= best_f_q) begin
							have_best_q <= 1'b1;
							best_f_q    <= rd_s1.freq;
							best_i_q    <= cmp_idx_s1;
						end
					end else if (!have_alt_q || rd_s1.freq <= alt_f_q) begin
						have_alt_q <= 1'b1;
						alt_f_q    <= rd_s1.freq;
						alt_i_q    <= cmp_idx_s1;
					end
				end else begin
					if (rd_s1.freq >= target_q) begin
						if (!have_best_q || rd_s1.freq <= best_f_q) begin
							have_best_q <= 1'b1;
							best_f_q    <= rd_s1.freq;
							best_i_q    <= cmp_idx_s1;
						end
					end else if (!have_alt_q || rd_s1.freq >= alt_f_q) begin
						have_alt_q <= 1'b1;
						alt_f_q    <= rd_s1.freq;
						alt_i_q    <= cmp_idx_s1;
					end
				end
			end

			case (uw.op)
				fops_pkg::OP_ACCEPT: begin
					if (req_accept) begin
						item_q   <= req;
						high_q   <= req.relation_high;
						old_q    <= current_q;
						status_q <= fops_pkg::STATUS_OK;
						chosen_q <= '0;
					end
				end
				fops_pkg::OP_CLAMP_LO: begin
					target_q    <= lo_a;
					cnt_q       <= '0;
					have_best_q <= 1'b0;
					have_alt_q  <= 1'b0;
				end
				fops_pkg::OP_CLAMP_HI: begin
					target_q <= hi_a;
				end
				fops_pkg::OP_SCAN: begin
					high_q     <= high_q || (target_q == policy_max_q)
					              || (target_q == qos_max_q);
					cmp_idx_s1 <= cnt_q[IDX_W-1:0];
					cnt_q      <= cnt_inc[CNT_W-1:0];
				end
				fops_pkg::OP_DECIDE: begin
					if (have_best_q) begin
						chosen_q  <= fops_pkg::index_t'(best_i_q);
						current_q <= best_f_q;
					end else if (have_alt_q) begin
						chosen_q  <= fops_pkg::index_t'(alt_i_q);
						current_q <= alt_f_q;
					end else begin
						status_q <= fops_pkg::STATUS_NO_ENTRY;
					end
				end
				fops_pkg::OP_BUSY: begin
					status_q <= fops_pkg::STATUS_BUSY;
				end
				fops_pkg::OP_SAVE: begin
					saved_q <= current_q;
				end
				fops_pkg::OP_PARK: begin
					current_q   <= rd_s1.freq;
					suspended_q <= 1'b1;
				end
				fops_pkg::OP_RESTORE: begin
					current_q   <= saved_q;
					suspended_q <= 1'b0;
				end
				default: ;
			endcase

			// output register
			if (uw.op == fops_pkg::OP_EMIT && !out_blocked) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= '{status: status_q, chosen_index: chosen_q,
				                 current_khz: current_q,
				                 changed: (current_q != old_q)};
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire
